@@ rtl/core/lz4d_pkg.sv @@
// Shared types and constants of the LZ4 block decompressor.
`default_nettype none
package lz4d_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 65536;
  localparam logic [31:0] CAPACITY_RESET    = 32'd65536;
  localparam logic [31:0] MATCH_BASE_LEN    = 32'd4;
  localparam logic [3:0]  NIBBLE_ESCAPE     = 4'hF;
  localparam logic [7:0]  RUN_CONTINUE      = 8'hFF;

  typedef enum logic [2:0] {
    PH_TOKEN   = 3'd0,
    PH_LITEXT  = 3'd1,
    PH_LIT     = 3'd2,
    PH_OFFLO   = 3'd3,
    PH_OFFHI   = 3'd4,
    PH_MATEXT  = 3'd5,
    PH_COPY    = 3'd6,
    PH_DISCARD = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BUSY   = 3'd1,
    ST_DONE   = 3'd2,
    ST_BADOFF = 3'd3,
    ST_OVER   = 3'd4,
    ST_TRUNC  = 3'd5,
    ST_DISC   = 3'd6
  } status_t;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result of one word as decided by the parser.
  typedef struct packed {
    logic        has_byte;   // a byte is produced and enters the history
    logic        is_copy;    // the byte comes from the history read
    logic [7:0]  lit_byte;   // literal byte, zero when none
    status_t     status;
    logic [31:0] total;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/lz4_block_decompressor_core.sv @@
// Top level of the LZ4 block decompressor: stream ports, result pipeline, history.
`default_nettype none
// LZ4 block decompressor. Compressed bytes (tuser = 0) and match ticks
// (tuser = 1) enter on the slave stream, one word per cycle; tlast marks the
// final compressed byte of a block. Every accepted word yields exactly one
// result word on the master stream: the parser updates its state in the cycle
// of acceptance and issues the history read, then a stage register picks the
// byte (literal, history read data, or the byte forwarded from the word just
// ahead when a short offset hits the entry being written) and, when it
// advances, writes it into the 64 KiB history and loads the output register.
// Sustained rate is one word per cycle, limited only by tready on the master
// side; the history memory has one write and one read port, and an offset of
// one is served by forwarding without a bubble. The history needs no clearing
// pass: the offset check keeps every read within bytes written in the current
// block. The user writes output_capacity through the cfg channel only while
// the block is idle, which the block does not enforce; it resets to 65536.
module lz4_block_decompressor_core #(
  parameter int unsigned HISTORY_DEPTH = lz4d_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: output_capacity
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] command
  input  wire logic        s_axis_tlast,   // end_of_block
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] total_bytes
  output logic      [3:0]  m_axis_tuser    // [0] out_valid, [3:1] status
);
  import lz4d_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic          accept;
  res_t          res;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    mem_q;

  // Stage between parser and output register.
  logic          p_valid;
  res_t          p_info;
  logic [AW-1:0] p_waddr;
  logic          p_fwd;
  logic [7:0]    p_fwd_byte;
  logic [7:0]    p_byte;
  logic          p_go;

  // Output register.
  logic          o_valid;
  res_t          o_info;
  logic [7:0]    o_byte;

  assign cfg_ready     = 1'b1;
  assign p_go          = p_valid && (!o_valid || m_axis_tready);
  assign s_axis_tready = !p_valid || p_go;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lz4d_parser #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .command      (s_axis_tuser),
    .data_byte    (s_axis_tdata),
    .end_of_block (s_axis_tlast),
    .res          (res),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr)
  );

  // Write the byte of the advancing stage; read the copy source on accept.
  lz4d_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (p_go && p_info.has_byte),
    .waddr (p_waddr),
    .wdata (p_byte),
    .re    (accept && res.is_copy),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  // Pick the produced byte: forwarded, from the history, or the literal.
  always_comb begin
    if (p_info.is_copy) begin
      p_byte = p_fwd ? p_fwd_byte : mem_q;
    end else begin
      p_byte = p_info.lit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_go) begin
      p_valid <= 1'b0;
    end
  end

  // Capture the word; flag a copy read of the entry written in this same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_info     <= res;
      p_waddr    <= wr_addr;
      p_fwd      <= res.is_copy && p_go && p_info.has_byte && (p_waddr == rd_addr);
      p_fwd_byte <= p_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (p_go) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_go) begin
      o_info <= p_info;
      o_byte <= p_byte;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {o_info.total, o_byte};
  assign m_axis_tuser  = {o_info.status, o_info.has_byte};

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    p_valid && o_valid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while the result pipeline is full");

  a_fwd_on_copy: assert property (@(posedge clk) disable iff (rst)
    p_valid && p_fwd |-> p_info.is_copy)
    else $error("forwarded byte on a word that is not a copy");

  a_copy_has_byte: assert property (@(posedge clk) disable iff (rst)
    p_valid && p_info.is_copy |-> p_info.has_byte)
    else $error("copy word without a produced byte");

  a_advance_loads_out: assert property (@(posedge clk) disable iff (rst)
    p_go |=> o_valid)
    else $error("advancing word did not reach the output register");
endmodule
`default_nettype wire

@@ rtl/core/lz4d_history.sv @@
// History memory: one write port, one registered read port.
`default_nettype none
module lz4d_history #(
  parameter int unsigned HISTORY_DEPTH = lz4d_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
  input  wire logic [7:0]                       wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
  output logic      [7:0]                       rdata
);
  logic [7:0] mem [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/lz4d_parser.sv @@
// Sequence parser: token, lengths, literals, offset and match bookkeeping.
`default_nettype none
module lz4d_parser #(
  parameter int unsigned HISTORY_DEPTH = lz4d_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [31:0]                      cfg_data,
  input  wire logic                             accept,
  input  wire logic                             command,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             end_of_block,
  output lz4d_pkg::res_t                        res,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] wr_addr
);
  import lz4d_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic [31:0] capacity;
  phase_t      phase, phase_next;
  logic [3:0]  match_nibble, match_nibble_next;
  logic [31:0] length_count, length_count_next;
  logic [15:0] offset_value, offset_value_next;
  logic [31:0] produced_count, produced_count_next;
  logic        end_seen, end_seen_next;

  logic [32:0] ext_sum;
  logic [31:0] fit_len;
  logic [32:0] fit_sum;
  logic        fits;
  logic [15:0] off_cand;
  logic        off_bad;
  logic [31:0] copy_src;
  logic        do_close;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TOKEN;
      match_nibble   <= '0;
      length_count   <= '0;
      offset_value   <= '0;
      produced_count <= '0;
      end_seen       <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      match_nibble   <= match_nibble_next;
      length_count   <= length_count_next;
      offset_value   <= offset_value_next;
      produced_count <= produced_count_next;
      end_seen       <= end_seen_next;
    end
  end

  // Shared length arithmetic: one extension add, one capacity compare.
  always_comb begin
    ext_sum = {1'b0, length_count} + {25'd0, data_byte};
    unique case (phase)
      PH_TOKEN:             fit_len = {28'd0, data_byte[7:4]};
      PH_OFFHI:             fit_len = {28'd0, match_nibble} + MATCH_BASE_LEN;
      PH_LITEXT, PH_MATEXT: fit_len = ext_sum[31:0];
      default:              fit_len = length_count;
    endcase
    fit_sum  = {1'b0, produced_count} + {1'b0, fit_len};
    fits     = fit_sum <= {1'b0, capacity};
    off_cand = (phase == PH_OFFHI) ? {data_byte, offset_value[7:0]} : offset_value;
    off_bad  = (off_cand == 16'd0) || ({16'd0, off_cand} > produced_count);
    copy_src = produced_count - {16'd0, offset_value};
    rd_addr  = copy_src[AW-1:0];
    wr_addr  = produced_count[AW-1:0];
  end

  always_comb begin
    phase_next          = phase;
    match_nibble_next   = match_nibble;
    length_count_next   = length_count;
    offset_value_next   = offset_value;
    produced_count_next = produced_count;
    end_seen_next       = end_seen;
    do_close            = 1'b0;
    res                 = '{has_byte: 1'b0, is_copy: 1'b0, lit_byte: 8'd0,
                            status: ST_OK, total: 32'd0};

    if (command == CMD_TICK) begin
      if (phase == PH_COPY) begin
        res.has_byte        = 1'b1;
        res.is_copy         = 1'b1;
        produced_count_next = produced_count + 32'd1;
        length_count_next   = length_count - 32'd1;
        if (length_count == 32'd1) begin
          if (end_seen) begin
            res.status = ST_DONE;
            res.total  = produced_count + 32'd1;
            do_close   = 1'b1;
          end else begin
            phase_next = PH_TOKEN;
          end
        end
      end else if (phase == PH_DISCARD) begin
        res.status = ST_DISC;
      end
    end else begin
      unique case (phase)
        PH_COPY: begin
          res.status = ST_BUSY;
        end
        PH_DISCARD: begin
          res.status = ST_DISC;
          do_close   = end_of_block;
        end
        PH_TOKEN: begin
          match_nibble_next = data_byte[3:0];
          if (end_of_block) begin
            do_close = 1'b1;
            if (data_byte[7:4] != 4'd0) begin
              res.status = ST_TRUNC;
            end else begin
              res.status = ST_DONE;
              res.total  = produced_count;
            end
          end else begin
            length_count_next = {28'd0, data_byte[7:4]};
            if (data_byte[7:4] == NIBBLE_ESCAPE) begin
              phase_next = PH_LITEXT;
            end else if (data_byte[7:4] == 4'd0) begin
              phase_next = PH_OFFLO;
            end else if (!fits) begin
              res.status = ST_OVER;
              phase_next = PH_DISCARD;
            end else begin
              phase_next = PH_LIT;
            end
          end
        end
        PH_LITEXT: begin
          if (ext_sum[32]) begin
            res.status = ST_OVER;
            do_close   = end_of_block;
            phase_next = PH_DISCARD;
          end else if (end_of_block) begin
            res.status = ST_TRUNC;
            do_close   = 1'b1;
          end else begin
            length_count_next = ext_sum[31:0];
            if (data_byte != RUN_CONTINUE) begin
              if (!fits) begin
                res.status = ST_OVER;
                phase_next = PH_DISCARD;
              end else begin
                phase_next = PH_LIT;
              end
            end
          end
        end
        PH_LIT: begin
          if (end_of_block && length_count != 32'd1) begin
            res.status = ST_TRUNC;
            do_close   = 1'b1;
          end else begin
            res.has_byte        = 1'b1;
            res.lit_byte        = data_byte;
            produced_count_next = produced_count + 32'd1;
            length_count_next   = length_count - 32'd1;
            if (end_of_block) begin
              res.status = ST_DONE;
              res.total  = produced_count + 32'd1;
              do_close   = 1'b1;
            end else if (length_count == 32'd1) begin
              phase_next = PH_OFFLO;
            end
          end
        end
        PH_OFFLO: begin
          if (end_of_block) begin
            res.status = ST_TRUNC;
            do_close   = 1'b1;
          end else begin
            offset_value_next = {8'd0, data_byte};
            phase_next        = PH_OFFHI;
          end
        end
        PH_OFFHI: begin
          offset_value_next = off_cand;
          length_count_next = {28'd0, match_nibble} + MATCH_BASE_LEN;
          if (match_nibble == NIBBLE_ESCAPE) begin
            if (end_of_block) begin
              res.status = ST_TRUNC;
              do_close   = 1'b1;
            end else begin
              phase_next = PH_MATEXT;
            end
          end else if (off_bad) begin
            res.status = ST_BADOFF;
            do_close   = end_of_block;
            phase_next = PH_DISCARD;
          end else if (!fits) begin
            res.status = ST_OVER;
            do_close   = end_of_block;
            phase_next = PH_DISCARD;
          end else begin
            phase_next    = PH_COPY;
            end_seen_next = end_of_block;
          end
        end
        PH_MATEXT: begin
          if (ext_sum[32]) begin
            res.status = ST_OVER;
            do_close   = end_of_block;
            phase_next = PH_DISCARD;
          end else begin
            length_count_next = ext_sum[31:0];
            if (data_byte == RUN_CONTINUE) begin
              if (end_of_block) begin
                res.status = ST_TRUNC;
                do_close   = 1'b1;
              end
            end else if (off_bad) begin
              res.status = ST_BADOFF;
              do_close   = end_of_block;
              phase_next = PH_DISCARD;
            end else if (!fits) begin
              res.status = ST_OVER;
              do_close   = end_of_block;
              phase_next = PH_DISCARD;
            end else begin
              phase_next    = PH_COPY;
              end_seen_next = end_of_block;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end

    // Close the block: return all sequence state to reset, keep the history.
    if (do_close) begin
      phase_next          = PH_TOKEN;
      match_nibble_next   = '0;
      length_count_next   = '0;
      offset_value_next   = '0;
      produced_count_next = '0;
      end_seen_next       = 1'b0;
    end
  end

  a_copy_has_length: assert property (@(posedge clk) disable iff (rst)
    phase == PH_COPY |-> length_count != 32'd0)
    else $error("copy phase with zero remaining length");
endmodule
`default_nettype wire
